// ===== hw/rtl/gobm_pkg.sv =====
// ----------------------------------------------------------------------------
// gobm_pkg
// shared types, constants and the cosine table generator of the oscillator
// bank mixer
// ----------------------------------------------------------------------------
package gobm_pkg;

	localparam int OSC_COUNT_DEF      = 256;
	localparam int COS_TABLE_BITS_DEF = 10;

	localparam int GLIDE_W  = 17;
	localparam int SAMPLE_W = 16;
	localparam int ACTIVE_W = 9;
	localparam int INDEX_W  = 8;
	localparam int STEP_W   = 32;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 9'd150;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
	localparam longint unsigned ONE_Q30    = 64'd1 << 30;

	typedef struct packed {
		logic [STEP_W-1:0] start_step;
		logic [STEP_W-1:0] end_step;
		logic [STEP_W-1:0] phase;
	} osc_entry_t;

	// cos of quarter index m, scaled by 32767, q30 taylor series
	function automatic logic [SAMPLE_W-1:0] quad_cos(input int unsigned m, input int bits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned pos;
		longint unsigned neg;
		longint unsigned sum;
		x    = (64'(m) * TWO_PI_Q30 + (64'd1 << (bits - 1))) >> bits;
		x2   = (x * x) >> 30;
		term = ONE_Q30;
		pos  = ONE_Q30;
		neg  = 64'd0;
		term = ((term * x2) >> 30) / 2;
		neg  = neg + term;
		term = ((term * x2) >> 30) / 12;
		pos  = pos + term;
		term = ((term * x2) >> 30) / 30;
		neg  = neg + term;
		term = ((term * x2) >> 30) / 56;
		pos  = pos + term;
		term = ((term * x2) >> 30) / 90;
		neg  = neg + term;
		term = ((term * x2) >> 30) / 132;
		pos  = pos + term;
		term = ((term * x2) >> 30) / 182;
		neg  = neg + term;
		term = ((term * x2) >> 30) / 240;
		pos  = pos + term;
		sum  = (pos > neg) ? (pos - neg) : 64'd0;
		if (sum > ONE_Q30) begin
			sum = ONE_Q30;
		end
		return SAMPLE_W'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
	endfunction

	// full-turn table entry k, mirrored from the first quadrant
	function automatic logic signed [SAMPLE_W-1:0] cos_entry(input int unsigned k,
		input int bits);
		int unsigned quarter;
		int unsigned tsize;
		logic [SAMPLE_W-1:0] v;
		quarter = 32'd1 << (bits - 2);
		tsize   = 32'd1 << bits;
		if (k <= quarter) begin
			v = quad_cos(k, bits);
		end else if (k <= 2 * quarter) begin
			v = SAMPLE_W'(0) - quad_cos(2 * quarter - k, bits);
		end else if (k <= 3 * quarter) begin
			v = SAMPLE_W'(0) - quad_cos(k - 2 * quarter, bits);
		end else begin
			v = quad_cos(tsize - k, bits);
		end
		return $signed(v);
	endfunction

endpackage

// ===== hw/rtl/gobm_osc_ram.sv =====
// ----------------------------------------------------------------------------
// gobm_osc_ram
// oscillator state memory: start step, end step and phase per entry, one
// write port and one registered read port
// ----------------------------------------------------------------------------
module gobm_osc_ram #(
	parameter int DEPTH = gobm_pkg::OSC_COUNT_DEF,
	parameter int AW    = 8
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  gobm_pkg::osc_entry_t wr_data,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output gobm_pkg::osc_entry_t rd_data
);

	gobm_pkg::osc_entry_t mem [DEPTH];
	gobm_pkg::osc_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/gobm_cos_rom.sv =====
// ----------------------------------------------------------------------------
// gobm_cos_rom
// cosine lookup table built at elaboration, registered read
// ----------------------------------------------------------------------------
module gobm_cos_rom #(
	parameter int COS_TABLE_BITS = gobm_pkg::COS_TABLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  rd_en,
	input  logic [COS_TABLE_BITS-1:0]             rd_addr,
	output logic signed [gobm_pkg::SAMPLE_W-1:0]  rd_data
);

	localparam int TABLE_SIZE = 1 << COS_TABLE_BITS;

	logic signed [gobm_pkg::SAMPLE_W-1:0] rom [TABLE_SIZE];
	logic signed [gobm_pkg::SAMPLE_W-1:0] rd_data_q;

	for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_rom
		assign rom[k] = gobm_pkg::cos_entry(k, COS_TABLE_BITS);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= rom[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/gobm_div.sv =====
// ----------------------------------------------------------------------------
// gobm_div
// signed by unsigned restoring divider, one quotient bit per cycle,
// truncates toward zero, divide by zero gives zero
// ----------------------------------------------------------------------------
module gobm_div #(
	parameter int DIVIDEND_W = 25,
	parameter int DIVISOR_W  = 9
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [DIVIDEND_W-1:0]         dividend,
	input  logic [DIVISOR_W-1:0]                 divisor,
	output logic                                 done,
	output logic signed [gobm_pkg::SAMPLE_W-1:0] quotient
);

	localparam int CW = $clog2(DIVIDEND_W + 1);

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_FIX
	} div_state_t;

	div_state_t                    state_q;
	logic [CW-1:0]                 cnt_q;
	logic                          done_q;
	logic [DIVIDEND_W-1:0]         quo_q;
	logic [DIVISOR_W-1:0]          rem_q;
	logic [DIVISOR_W-1:0]          divisor_q;
	logic                          neg_q;
	logic                          zero_q;
	logic signed [gobm_pkg::SAMPLE_W-1:0] result_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    trial_sub;
	logic                  fits;
	logic [DIVIDEND_W-1:0] magnitude;

	assign magnitude = dividend[DIVIDEND_W-1] ? (DIVIDEND_W'(0) - dividend) : dividend;
	assign trial     = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits      = trial >= {1'b0, divisor_q};
	assign trial_sub = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				DIV_IDLE: begin
					if (start) begin
						cnt_q   <= CW'(DIVIDEND_W);
						state_q <= DIV_RUN;
					end
				end
				DIV_RUN: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= DIV_FIX;
					end
				end
				DIV_FIX: begin
					done_q  <= 1'b1;
					state_q <= DIV_IDLE;
				end
				default: begin
					state_q <= DIV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			quo_q     <= magnitude;
			rem_q     <= '0;
			divisor_q <= divisor;
			neg_q     <= dividend[DIVIDEND_W-1];
			zero_q    <= (divisor == '0);
		end else if (state_q == DIV_RUN) begin
			if (fits) begin
				rem_q <= trial_sub[DIVISOR_W-1:0];
			end else begin
				rem_q <= trial[DIVISOR_W-1:0];
			end
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end else if (state_q == DIV_FIX) begin
			if (zero_q) begin
				result_q <= '0;
			end else if (neg_q) begin
				result_q <= $signed(gobm_pkg::SAMPLE_W'(0) - quo_q[gobm_pkg::SAMPLE_W-1:0]);
			end else begin
				result_q <= $signed(quo_q[gobm_pkg::SAMPLE_W-1:0]);
			end
		end
	end

	assign done     = done_q;
	assign quotient = result_q;

endmodule

// ===== hw/rtl/gliding_oscillator_bank_mixer_core.sv =====
// ----------------------------------------------------------------------------
// gliding_oscillator_bank_mixer_core
// bank of gliding phase-accumulator oscillators mixed into one pcm sample
//
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    command, osc_index, start_increment,
//                                            end_increment, start_phase, glide
// out      output     out_valid / out_ready  sample
// cfg      input      cfg_valid / cfg_ready  active_oscillators
//
// a load writes entry osc_index if it lies below the active count; a tick walks the
// active oscillators one per cycle through the shared glide multiplier and phase
// adder, then the serial divider works through the sum bit by bit and the result
// goes to the output register behind out_valid
// after reset a clearing pass writes OSC_COUNT memory entries, in_ready low
// the result sits in an output register, so a stalled out channel holds the next
// tick in ST_OUT, and while it waits there in_ready is low for any load
// ----------------------------------------------------------------------------
module gliding_oscillator_bank_mixer_core #(
	parameter int OSC_COUNT      = gobm_pkg::OSC_COUNT_DEF,
	parameter int COS_TABLE_BITS = gobm_pkg::COS_TABLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  command,
	input  logic [gobm_pkg::INDEX_W-1:0]          osc_index,
	input  logic [gobm_pkg::STEP_W-1:0]           start_increment,
	input  logic [gobm_pkg::STEP_W-1:0]           end_increment,
	input  logic [gobm_pkg::STEP_W-1:0]           start_phase,
	input  logic [gobm_pkg::GLIDE_W-1:0]          glide,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [gobm_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [gobm_pkg::ACTIVE_W-1:0]         active_oscillators
);

	localparam int AW    = (OSC_COUNT > 1) ? $clog2(OSC_COUNT) : 1;
	localparam int CNT_W = $clog2(OSC_COUNT + 1);
	localparam int SUM_W = gobm_pkg::SAMPLE_W + CNT_W;
	localparam int SW    = gobm_pkg::STEP_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              idx_q;
	logic [gobm_pkg::ACTIVE_W-1:0] active_q;
	logic                          out_valid_q;
	logic                          div_start_q;
	logic                          v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [gobm_pkg::GLIDE_W-1:0]         glide_q;
	logic signed [SUM_W-1:0]              sum_q;
	logic signed [gobm_pkg::SAMPLE_W-1:0] sample_q;

	logic [AW-1:0]      addr_s1, addr_s2, addr_s3, addr_s4;
	logic signed [50:0] prod_s2;
	logic [SW-1:0]      start_inc_s2, end_inc_s2, phase_s2;
	logic [SW-1:0]      start_inc_s3, end_inc_s3, phase_s3, inc_s3;
	logic [SW-1:0]      start_inc_s4, end_inc_s4, phase_s4;

	logic [CNT_W-1:0]     n_eff;
	logic                 in_fire;
	logic                 issue;
	logic                 pipe_busy;
	logic                 out_load;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	gobm_pkg::osc_entry_t wr_data;
	gobm_pkg::osc_entry_t rd_data;
	logic signed [32:0]   diff_s1;
	logic signed [17:0]   glide_sx;
	logic signed [gobm_pkg::SAMPLE_W-1:0] cos_val;
	logic                 div_done;
	logic signed [gobm_pkg::SAMPLE_W-1:0] div_quot;

	assign n_eff = (32'(active_q) > OSC_COUNT) ? CNT_W'(OSC_COUNT) : CNT_W'(active_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign issue     = (state_q == ST_WALK);
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			idx_q       <= '0;
			active_q    <= gobm_pkg::ACTIVE_RESET;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			if (cfg_valid && cfg_ready) begin
				active_q <= active_oscillators;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + CNT_W'(1);
					if (idx_q == CNT_W'(OSC_COUNT - 1)) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire && command == gobm_pkg::CMD_TICK) begin
						idx_q <= '0;
						if (n_eff == '0) begin
							state_q <= ST_DRAIN;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					idx_q <= idx_q + CNT_W'(1);
					if (idx_q == n_eff - CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// oscillator datapath
	assign diff_s1  = $signed({1'b0, rd_data.end_step}) - $signed({1'b0, rd_data.start_step});
	assign glide_sx = $signed({1'b0, glide_q});

	always_ff @(posedge clk) begin
		if (in_fire) begin
			glide_q <= glide;
			sum_q   <= '0;
		end else if (v_s5) begin
			sum_q <= sum_q + {{(SUM_W - gobm_pkg::SAMPLE_W){cos_val[gobm_pkg::SAMPLE_W-1]}},
				cos_val};
		end
		addr_s1      <= idx_q[AW-1:0];
		prod_s2      <= diff_s1 * glide_sx;
		start_inc_s2 <= rd_data.start_step;
		end_inc_s2   <= rd_data.end_step;
		phase_s2     <= rd_data.phase;
		addr_s2      <= addr_s1;
		inc_s3       <= start_inc_s2 + prod_s2[47:16];
		start_inc_s3 <= start_inc_s2;
		end_inc_s3   <= end_inc_s2;
		phase_s3     <= phase_s2;
		addr_s3      <= addr_s2;
		phase_s4     <= phase_s3 + inc_s3;
		start_inc_s4 <= start_inc_s3;
		end_inc_s4   <= end_inc_s3;
		addr_s4      <= addr_s3;
		if (out_load) begin
			sample_q <= div_quot;
		end
	end

	// memory write select: clearing pass, phase write back, load
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[AW-1:0];
		wr_data = '0;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
		end else if (v_s4) begin
			wr_en              = 1'b1;
			wr_addr            = addr_s4;
			wr_data.start_step = start_inc_s4;
			wr_data.end_step   = end_inc_s4;
			wr_data.phase      = phase_s4;
		end else begin
			wr_en              = in_fire && (command == gobm_pkg::CMD_LOAD)
				&& (32'(osc_index) < 32'(n_eff));
			wr_addr            = AW'(osc_index);
			wr_data.start_step = start_increment;
			wr_data.end_step   = end_increment;
			wr_data.phase      = start_phase;
		end
	end

	gobm_osc_ram #(
		.DEPTH (OSC_COUNT),
		.AW    (AW)
	) u_osc_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	gobm_cos_rom #(
		.COS_TABLE_BITS (COS_TABLE_BITS)
	) u_cos_rom (
		.clk     (clk),
		.rd_en   (v_s4),
		.rd_addr (phase_s4[SW-1 -: COS_TABLE_BITS]),
		.rd_data (cos_val)
	);

	gobm_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (sum_q),
		.divisor  (n_eff),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

endmodule
